@@ design/ctt_pkg.sv @@
// Shared types, constants and helper functions for the config text tokenizer.
package ctt_pkg;

	localparam int MAX_TEXT_BYTES = 65536;
	localparam int POS_CAP_I = (MAX_TEXT_BYTES < 131071) ? MAX_TEXT_BYTES : 131071;
	localparam int LEN_CAP_I = (MAX_TEXT_BYTES - 1 < 65535) ? (MAX_TEXT_BYTES - 1) : 65535;
	localparam logic [16:0] POS_CAP = 17'(POS_CAP_I);
	localparam logic [15:0] LEN_CAP = 16'(LEN_CAP_I);

	// token queue depth and pointer width
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	typedef enum logic [3:0] {
		KIND_END     = 4'd0,
		KIND_NEWLINE = 4'd1,
		KIND_OPEN    = 4'd2,
		KIND_CLOSE   = 4'd3,
		KIND_EQUALS  = 4'd4,
		KIND_STRING  = 4'd5,
		KIND_INT     = 4'd6,
		KIND_IDENT   = 4'd7,
		KIND_BOOL    = 4'd8,
		KIND_ERROR   = 4'd9
	} tok_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_STRING  = 3'd1,
		MODE_INT     = 3'd2,
		MODE_IDENT   = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_DONE    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KW_NONE  = 2'd0,
		KW_TRUE  = 2'd1,
		KW_FALSE = 2'd2
	} kw_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [16:0] off;
		logic [15:0] len;
		logic [16:0] line;
		logic [16:0] col;
		logic        bval;
		logic        last;
	} tok_t;

	typedef struct packed {
		mode_t       mode;
		logic        qdbl;
		logic [16:0] pos;
		logic [16:0] line;
		logic [16:0] col;
		logic [16:0] poff;
		logic [16:0] pline;
		logic [16:0] pcol;
		logic [15:0] plen;
		kw_t         kw;
	} lex_state_t;

	// what one lexer step hands to the token queue
	typedef struct packed {
		logic [1:0] n;
		tok_t       tok0;
		tok_t       tok1;
	} lex_out_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           room2;
	} tokq_stat_t;

	localparam lex_state_t LEX_RESET = '{
		mode:  MODE_IDLE,
		qdbl:  1'b0,
		pos:   17'd0,
		line:  17'd1,
		col:   17'd1,
		poff:  17'd0,
		pline: 17'd1,
		pcol:  17'd1,
		plen:  16'd0,
		kw:    KW_NONE
	};

	function automatic logic [16:0] inc_pos(input logic [16:0] v);
		return (v < POS_CAP) ? v + 17'd1 : POS_CAP;
	endfunction

	function automatic logic [15:0] inc_len(input logic [15:0] v);
		return (v < LEN_CAP) ? v + 16'd1 : LEN_CAP;
	endfunction

	function automatic logic [7:0] true_char(input logic [1:0] i);
		logic [7:0] c;
		unique case (i)
			2'd0: c = 8'h74;
			2'd1: c = 8'h72;
			2'd2: c = 8'h75;
			default: c = 8'h65;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] false_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0: c = 8'h66;
			3'd1: c = 8'h61;
			3'd2: c = 8'h6C;
			3'd3: c = 8'h73;
			3'd4: c = 8'h65;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// keyword prefix still matching after appending c at index i
	function automatic kw_t kw_next(input kw_t kw, input logic [15:0] i, input logic [7:0] c);
		kw_t r;
		r = kw;
		unique case (kw)
			KW_TRUE: begin
				if (!((i < 16'd4) && (c == true_char(i[1:0])))) r = KW_NONE;
			end
			KW_FALSE: begin
				if (!((i < 16'd5) && (c == false_char(i[2:0])))) r = KW_NONE;
			end
			default: r = kw;
		endcase
		return r;
	endfunction

endpackage

@@ design/ctt_lex.sv @@
// Lexer step: current state plus one input item gives next state and up to two tokens.
module ctt_lex (
	input  ctt_pkg::lex_state_t st,
	input  logic [7:0]          ch,
	input  logic                endm,
	output ctt_pkg::lex_state_t nx,
	output ctt_pkg::lex_out_t   res
);

	logic is_digit, is_alpha, is_word, is_blank, is_nl, is_quote;
	logic [7:0] close_quote;
	ctt_pkg::tok_t close_tok, fresh_tok, end_tok, tok_a, tok_b;
	logic close_v, fresh_v, va, vb, fresh, adv;

	assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
	assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
	assign is_word  = is_alpha || is_digit || (ch == ctt_pkg::CH_USCORE);
	assign is_blank = (ch == ctt_pkg::CH_SPACE) || (ch == ctt_pkg::CH_TAB) ||
		(ch == ctt_pkg::CH_VT) || (ch == ctt_pkg::CH_FF) || (ch == ctt_pkg::CH_CR);
	assign is_nl    = (ch == ctt_pkg::CH_NL);
	assign is_quote = (ch == ctt_pkg::CH_DQUOTE) || (ch == ctt_pkg::CH_SQUOTE);
	assign close_quote = st.qdbl ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE;

	// end token sits at the current position, length zero
	always_comb begin
		end_tok      = '0;
		end_tok.kind = ctt_pkg::KIND_END;
		end_tok.off  = st.pos;
		end_tok.line = st.line;
		end_tok.col  = st.col;
	end

	// token that closes whatever is pending
	always_comb begin
		close_tok      = '0;
		close_tok.line = st.pline;
		close_tok.col  = st.pcol;
		close_tok.off  = st.poff;
		close_tok.len  = st.plen;
		close_v        = 1'b1;
		unique case (st.mode)
			ctt_pkg::MODE_STRING: begin
				close_tok.kind = ctt_pkg::KIND_ERROR;
				close_tok.off  = st.pos;
				close_tok.len  = 16'd1;
			end
			ctt_pkg::MODE_INT: begin
				close_tok.kind = ctt_pkg::KIND_INT;
			end
			ctt_pkg::MODE_IDENT: begin
				if (st.kw == ctt_pkg::KW_TRUE && st.plen == 16'd4) begin
					close_tok.kind = ctt_pkg::KIND_BOOL;
					close_tok.bval = 1'b1;
				end else if (st.kw == ctt_pkg::KW_FALSE && st.plen == 16'd5) begin
					close_tok.kind = ctt_pkg::KIND_BOOL;
				end else begin
					close_tok.kind = ctt_pkg::KIND_IDENT;
				end
			end
			default: begin
				close_tok.kind = ctt_pkg::KIND_ERROR;
				close_v        = 1'b0;
			end
		endcase
	end

	// single-byte token of a byte lexed from idle
	always_comb begin
		fresh_tok      = '0;
		fresh_tok.off  = st.pos;
		fresh_tok.len  = 16'd1;
		fresh_tok.line = st.line;
		fresh_tok.col  = st.col;
		fresh_v        = 1'b1;
		priority if (is_blank || is_quote || is_digit || is_alpha ||
			ch == ctt_pkg::CH_USCORE || ch == ctt_pkg::CH_HASH) begin
			fresh_tok.kind = ctt_pkg::KIND_ERROR;
			fresh_v        = 1'b0;
		end else if (is_nl) begin
			fresh_tok.kind = ctt_pkg::KIND_NEWLINE;
		end else if (ch == ctt_pkg::CH_OPEN) begin
			fresh_tok.kind = ctt_pkg::KIND_OPEN;
		end else if (ch == ctt_pkg::CH_CLOSE) begin
			fresh_tok.kind = ctt_pkg::KIND_CLOSE;
		end else if (ch == ctt_pkg::CH_EQ) begin
			fresh_tok.kind = ctt_pkg::KIND_EQUALS;
		end else begin
			fresh_tok.kind = ctt_pkg::KIND_ERROR;
		end
	end

	always_comb begin
		nx    = st;
		tok_a = close_tok;
		tok_b = end_tok;
		va    = 1'b0;
		vb    = 1'b0;
		fresh = 1'b0;
		adv   = 1'b0;
		if (endm) begin
			if (st.mode != ctt_pkg::MODE_DONE) begin
				va = close_v;
				vb = 1'b1;
			end
			nx = ctt_pkg::LEX_RESET;
		end else if (st.mode == ctt_pkg::MODE_DONE) begin
			nx = st;
		end else if (ch == ctt_pkg::CH_NUL) begin
			va      = close_v;
			vb      = 1'b1;
			nx.mode = ctt_pkg::MODE_DONE;
		end else begin
			unique case (st.mode)
				ctt_pkg::MODE_STRING: begin
					if (ch == close_quote) begin
						va            = 1'b1;
						tok_a.kind    = ctt_pkg::KIND_STRING;
						tok_a.off     = st.poff;
						tok_a.len     = st.plen;
						nx.mode       = ctt_pkg::MODE_IDLE;
						adv           = 1'b1;
					end else if (is_nl) begin
						va    = 1'b1;
						fresh = 1'b1;
					end else begin
						nx.plen = ctt_pkg::inc_len(st.plen);
						adv     = 1'b1;
					end
				end
				ctt_pkg::MODE_INT: begin
					if (is_digit) begin
						nx.plen = ctt_pkg::inc_len(st.plen);
						adv     = 1'b1;
					end else begin
						va    = 1'b1;
						fresh = 1'b1;
					end
				end
				ctt_pkg::MODE_IDENT: begin
					if (is_word) begin
						nx.kw   = ctt_pkg::kw_next(st.kw, st.plen, ch);
						nx.plen = ctt_pkg::inc_len(st.plen);
						adv     = 1'b1;
					end else begin
						va    = 1'b1;
						fresh = 1'b1;
					end
				end
				ctt_pkg::MODE_COMMENT: begin
					if (!is_nl) adv = 1'b1;
					else fresh = 1'b1;
				end
				default: fresh = 1'b1;
			endcase
			if (fresh) begin
				nx.mode = ctt_pkg::MODE_IDLE;
				vb      = fresh_v;
				tok_b   = fresh_tok;
				adv     = 1'b1;
				if (is_quote) begin
					nx.mode  = ctt_pkg::MODE_STRING;
					nx.poff  = ctt_pkg::inc_pos(st.pos);
					nx.pline = st.line;
					nx.pcol  = st.col;
					nx.plen  = 16'd0;
					nx.qdbl  = (ch == ctt_pkg::CH_DQUOTE);
				end else if (ch == ctt_pkg::CH_HASH) begin
					nx.mode = ctt_pkg::MODE_COMMENT;
				end else if (is_digit) begin
					nx.mode  = ctt_pkg::MODE_INT;
					nx.poff  = st.pos;
					nx.pline = st.line;
					nx.pcol  = st.col;
					nx.plen  = 16'd1;
				end else if (is_alpha || ch == ctt_pkg::CH_USCORE) begin
					nx.mode  = ctt_pkg::MODE_IDENT;
					nx.poff  = st.pos;
					nx.pline = st.line;
					nx.pcol  = st.col;
					nx.plen  = 16'd1;
					nx.kw    = (ch == 8'h74) ? ctt_pkg::KW_TRUE :
						(ch == 8'h66) ? ctt_pkg::KW_FALSE : ctt_pkg::KW_NONE;
				end
			end
			if (adv) begin
				nx.pos  = ctt_pkg::inc_pos(st.pos);
				nx.line = is_nl ? ctt_pkg::inc_pos(st.line) : st.line;
				nx.col  = is_nl ? 17'd1 : ctt_pkg::inc_pos(st.col);
			end
		end
	end

	// pack: the close token, if any, goes first
	always_comb begin
		res.n         = {1'b0, va} + {1'b0, vb};
		res.tok0      = va ? tok_a : tok_b;
		res.tok0.last = !(va && vb);
		res.tok1      = tok_b;
		res.tok1.last = 1'b1;
	end

endmodule

@@ design/ctt_tokq.sv @@
// Small token queue: takes up to two tokens a cycle, hands out one.
module ctt_tokq (
	input  logic                clk,
	input  logic                arst_n,
	input  ctt_pkg::lex_out_t   push,
	input  logic                pop,
	output ctt_pkg::tok_t       head,
	output logic                head_valid,
	output ctt_pkg::tokq_stat_t stat
);

	ctt_pkg::tok_t mem_q [ctt_pkg::QDEPTH];
	logic [ctt_pkg::QAW-1:0] wr_q, rd_q;
	logic [ctt_pkg::QCW-1:0] count_q;
	logic [ctt_pkg::QAW-1:0] wr_nxt;

	assign wr_nxt = wr_q + ctt_pkg::QAW'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_q] <= push.tok0;
		if (push.n == 2'd2) mem_q[wr_nxt] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + ctt_pkg::QAW'(push.n);
			if (pop) rd_q <= rd_q + ctt_pkg::QAW'(1);
			count_q <= count_q + ctt_pkg::QCW'(push.n) - ctt_pkg::QCW'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign head_valid = (count_q != '0);
	assign stat.count = count_q;
	assign stat.room2 = (count_q <= ctt_pkg::QCW'(ctt_pkg::QDEPTH - 2));

endmodule

@@ design/config_text_tokenizer_unit.sv @@
// Top level of the config text tokenizer: input stage, lexer state and token queue.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | char_byte, end_marker
//  out     | out_valid / out_ready | token_kind, start_offset, token_length,
//          |                       | token_line, token_column, bool_value,
//          |                       | last_of_run
//
// One item per cycle while the queue has room: an accepted item is registered in the
// input stage and lexed from there; when the step fires, its zero to two tokens are
// written into a four-entry queue, which offers its head token once the write is registered.
// The step waits while the queue has room for fewer than two tokens, so a run
// of two-token items is paced by the one-token-a-cycle output port.
// Reset: offset 0, line 1, column 1, empty queue; in_ready = stage empty or moving.
module config_text_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_marker,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  token_kind,
	output logic [16:0] start_offset,
	output logic [15:0] token_length,
	output logic [16:0] token_line,
	output logic [16:0] token_column,
	output logic        bool_value,
	output logic        last_of_run
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       endm_s1;

	// lexer state and step
	ctt_pkg::lex_state_t st_q, st_nxt;
	ctt_pkg::lex_out_t   lex_res, push;
	ctt_pkg::tokq_stat_t qstat;
	ctt_pkg::tok_t       head;
	logic                fire;

	assign fire     = valid_s1 && qstat.room2;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload holds until the stage moves
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= char_byte;
			endm_s1 <= end_marker;
		end
	end

	ctt_lex u_lex (
		.st   (st_q),
		.ch   (byte_s1),
		.endm (endm_s1),
		.nx   (st_nxt),
		.res  (lex_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ctt_pkg::LEX_RESET;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// nothing is queued unless the step really fires
	always_comb begin
		push   = lex_res;
		push.n = fire ? lex_res.n : 2'd0;
	end

	ctt_tokq u_tokq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_valid && out_ready),
		.head       (head),
		.head_valid (out_valid),
		.stat       (qstat)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.off;
	assign token_length = head.len;
	assign token_line   = head.line;
	assign token_column = head.col;
	assign bool_value   = head.bval;
	assign last_of_run  = head.last;

`ifndef SYNTH
	a_qcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= ctt_pkg::QCW'(ctt_pkg::QDEPTH))
		else $error("token queue count above depth");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !endm_s1 && st_q.mode == ctt_pkg::MODE_DONE) |-> (push.n == 2'd0))
		else $error("token after end of text");

	a_end_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && endm_s1) |=> (st_q.mode == ctt_pkg::MODE_IDLE && st_q.pos == 17'd0))
		else $error("end item did not re-arm lexer");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && !qstat.room2))
		else $error("input stalled with no work held");
`endif

endmodule

@@ bench/ctt_token_checker.sv @@
// Token checker for the config text tokenizer: mirrors the lexer and scores every output token.
module ctt_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_marker,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  token_kind,
	input  logic [16:0] start_offset,
	input  logic [15:0] token_length,
	input  logic [16:0] token_line,
	input  logic [16:0] token_column,
	input  logic        bool_value,
	input  logic        last_of_run,
	output int          mismatches,
	output int          outstanding
);

	localparam logic [31:0] WORD_TRUE  = "true";
	localparam logic [39:0] WORD_FALSE = "false";

	// mirrored lexer state
	ctt_pkg::mode_t mode;
	logic           dquote;
	logic [16:0]    pos;
	logic [16:0]    line;
	logic [16:0]    col;
	logic [16:0]    tok_off;
	logic [16:0]    tok_line;
	logic [16:0]    tok_col;
	logic [15:0]    tok_len;
	ctt_pkg::kw_t   kw;

	ctt_pkg::tok_t due_tokens[$];
	ctt_pkg::tok_t want;
	int            step_count;
	int            errs = 0;

	function automatic int bump(input int v, input int cap);
		return (v >= cap) ? cap : v + 1;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == ctt_pkg::CH_SPACE || c == ctt_pkg::CH_TAB || c == ctt_pkg::CH_VT
			|| c == ctt_pkg::CH_FF || c == ctt_pkg::CH_CR;
	endfunction

	function automatic void reset_lexer();
		mode     = ctt_pkg::MODE_IDLE;
		dquote   = 1'b0;
		pos      = 17'd0;
		line     = 17'd1;
		col      = 17'd1;
		tok_off  = 17'd0;
		tok_line = 17'd1;
		tok_col  = 17'd1;
		tok_len  = 16'd0;
		kw       = ctt_pkg::KW_NONE;
	endfunction

	function automatic void add_token(input ctt_pkg::tok_kind_t k, input logic [16:0] o,
			input logic [15:0] n, input logic [16:0] l, input logic [16:0] c, input logic b);
		ctt_pkg::tok_t t;
		t.kind = k;
		t.off  = o;
		t.len  = n;
		t.line = l;
		t.col  = c;
		t.bval = b;
		t.last = 1'b0;
		due_tokens.push_back(t);
		step_count++;
	endfunction

	function automatic void close_open_token();
		case (mode)
			ctt_pkg::MODE_STRING:
				add_token(ctt_pkg::KIND_ERROR, pos, 16'd1, tok_line, tok_col, 1'b0);
			ctt_pkg::MODE_INT:
				add_token(ctt_pkg::KIND_INT, tok_off, tok_len, tok_line, tok_col, 1'b0);
			ctt_pkg::MODE_IDENT: begin
				if (kw == ctt_pkg::KW_TRUE && tok_len == 16'd4)
					add_token(ctt_pkg::KIND_BOOL, tok_off, tok_len, tok_line, tok_col, 1'b1);
				else if (kw == ctt_pkg::KW_FALSE && tok_len == 16'd5)
					add_token(ctt_pkg::KIND_BOOL, tok_off, tok_len, tok_line, tok_col, 1'b0);
				else
					add_token(ctt_pkg::KIND_IDENT, tok_off, tok_len, tok_line, tok_col, 1'b0);
			end
			default: ;
		endcase
		mode = ctt_pkg::MODE_IDLE;
	endfunction

	function automatic void advance(input logic [7:0] c);
		if (c == ctt_pkg::CH_NL) begin
			line = 17'(bump(line, ctt_pkg::POS_CAP_I));
			col  = 17'd1;
		end else begin
			col = 17'(bump(col, ctt_pkg::POS_CAP_I));
		end
		pos = 17'(bump(pos, ctt_pkg::POS_CAP_I));
	endfunction

	function automatic void start_token(input ctt_pkg::mode_t m, input logic [16:0] o,
			input logic [15:0] n);
		mode     = m;
		tok_off  = o;
		tok_line = line;
		tok_col  = col;
		tok_len  = n;
	endfunction

	// byte seen with no token open
	function automatic void lex_fresh(input logic [7:0] c);
		if (is_blank(c)) begin
		end else if (c == ctt_pkg::CH_NL) begin
			add_token(ctt_pkg::KIND_NEWLINE, pos, 16'd1, line, col, 1'b0);
		end else if (c == ctt_pkg::CH_OPEN) begin
			add_token(ctt_pkg::KIND_OPEN, pos, 16'd1, line, col, 1'b0);
		end else if (c == ctt_pkg::CH_CLOSE) begin
			add_token(ctt_pkg::KIND_CLOSE, pos, 16'd1, line, col, 1'b0);
		end else if (c == ctt_pkg::CH_EQ) begin
			add_token(ctt_pkg::KIND_EQUALS, pos, 16'd1, line, col, 1'b0);
		end else if (c == ctt_pkg::CH_DQUOTE || c == ctt_pkg::CH_SQUOTE) begin
			start_token(ctt_pkg::MODE_STRING, 17'(bump(pos, ctt_pkg::POS_CAP_I)), 16'd0);
			dquote = (c == ctt_pkg::CH_DQUOTE);
		end else if (c == ctt_pkg::CH_HASH) begin
			mode = ctt_pkg::MODE_COMMENT;
		end else if (is_digit(c)) begin
			start_token(ctt_pkg::MODE_INT, pos, 16'd1);
		end else if (is_alpha(c) || c == ctt_pkg::CH_USCORE) begin
			start_token(ctt_pkg::MODE_IDENT, pos, 16'd1);
			kw = (c == "t") ? ctt_pkg::KW_TRUE : (c == "f") ? ctt_pkg::KW_FALSE
				: ctt_pkg::KW_NONE;
		end else begin
			add_token(ctt_pkg::KIND_ERROR, pos, 16'd1, line, col, 1'b0);
		end
		advance(c);
	endfunction

	function automatic void lex_byte(input logic [7:0] c);
		int idx;
		idx = int'(tok_len);
		case (mode)
			ctt_pkg::MODE_STRING: begin
				if (c == (dquote ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE)) begin
					add_token(ctt_pkg::KIND_STRING, tok_off, tok_len, tok_line, tok_col, 1'b0);
					mode = ctt_pkg::MODE_IDLE;
					advance(c);
					return;
				end
				if (c != ctt_pkg::CH_NL) begin
					tok_len = 16'(bump(tok_len, ctt_pkg::LEN_CAP_I));
					advance(c);
					return;
				end
				// newline breaks the string, then is lexed as a newline
				add_token(ctt_pkg::KIND_ERROR, pos, 16'd1, tok_line, tok_col, 1'b0);
				mode = ctt_pkg::MODE_IDLE;
			end
			ctt_pkg::MODE_INT: begin
				if (is_digit(c)) begin
					tok_len = 16'(bump(tok_len, ctt_pkg::LEN_CAP_I));
					advance(c);
					return;
				end
				close_open_token();
			end
			ctt_pkg::MODE_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == ctt_pkg::CH_USCORE) begin
					if (kw == ctt_pkg::KW_TRUE
							&& !(idx < 4 && c == WORD_TRUE[8*(3-idx) +: 8]))
						kw = ctt_pkg::KW_NONE;
					else if (kw == ctt_pkg::KW_FALSE
							&& !(idx < 5 && c == WORD_FALSE[8*(4-idx) +: 8]))
						kw = ctt_pkg::KW_NONE;
					tok_len = 16'(bump(tok_len, ctt_pkg::LEN_CAP_I));
					advance(c);
					return;
				end
				close_open_token();
			end
			ctt_pkg::MODE_COMMENT: begin
				if (c != ctt_pkg::CH_NL) begin
					advance(c);
					return;
				end
				mode = ctt_pkg::MODE_IDLE;
			end
			default: mode = ctt_pkg::MODE_IDLE;
		endcase
		lex_fresh(c);
	endfunction

	function automatic void lex_step(input logic [7:0] c, input logic e);
		ctt_pkg::tok_t t;
		step_count = 0;
		if (e) begin
			if (mode != ctt_pkg::MODE_DONE) begin
				close_open_token();
				add_token(ctt_pkg::KIND_END, pos, 16'd0, line, col, 1'b0);
			end
			reset_lexer();
		end else if (mode == ctt_pkg::MODE_DONE) begin
		end else if (c == ctt_pkg::CH_NUL) begin
			close_open_token();
			add_token(ctt_pkg::KIND_END, pos, 16'd0, line, col, 1'b0);
			mode = ctt_pkg::MODE_DONE;
		end else begin
			lex_byte(c);
		end
		if (step_count > 0) begin
			t = due_tokens.pop_back();
			t.last = 1'b1;
			due_tokens.push_back(t);
		end
	endfunction

	initial reset_lexer();

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_lexer();
			due_tokens.delete();
		end else begin
			if (in_valid && in_ready)
				lex_step(char_byte, end_marker);
			if (out_valid && out_ready) begin
				if (due_tokens.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected token: kind %0d off %0d len %0d line %0d col %0d",
							token_kind, start_offset, token_length, token_line, token_column);
				end else begin
					want = due_tokens.pop_front();
					if (token_kind !== want.kind || start_offset !== want.off
							|| token_length !== want.len || token_line !== want.line
							|| token_column !== want.col || bool_value !== want.bval
							|| last_of_run !== want.last) begin
						errs++;
						if (errs <= 10)
							$display({"token mismatch (exp/act): kind %0d/%0d off %0d/%0d ",
								"len %0d/%0d line %0d/%0d col %0d/%0d bool %0d/%0d last %0d/%0d"},
								want.kind, token_kind, want.off, start_offset,
								want.len, token_length, want.line, token_line,
								want.col, token_column, want.bval, bool_value,
								want.last, last_of_run);
					end
				end
			end
		end
		mismatches  <= errs;
		outstanding <= due_tokens.size();
	end

endmodule

@@ bench/tb.sv @@
// Testbench top for the config text tokenizer: stimulus, ready pattern, watchdog and verdict.
module tb;

	// cycles with no item moving on either channel before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	// random items to send after the directed part
	localparam int RANDOM_ITEMS = 1850;
	// idle tail after the checker drains, padding generously past the lexer step and queue
	localparam int TAIL_CYCLES  = 16;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [7:0]  char_byte  = 8'h00;
	logic        end_marker = 1'b0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [3:0]  token_kind;
	logic [16:0] start_offset;
	logic [15:0] token_length;
	logic [16:0] token_line;
	logic [16:0] token_column;
	logic        bool_value;
	logic        last_of_run;

	int fails;
	int outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent    = 0;
	int quiet_cycles  = 0;

	always #5 clk = ~clk;

	config_text_tokenizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_byte(char_byte), .end_marker(end_marker),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset), .token_length(token_length),
		.token_line(token_line), .token_column(token_column),
		.bool_value(bool_value), .last_of_run(last_of_run)
	);

	ctt_token_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_byte(char_byte), .end_marker(end_marker),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset), .token_length(token_length),
		.token_line(token_line), .token_column(token_column),
		.bool_value(bool_value), .last_of_run(last_of_run),
		.mismatches(fails), .outstanding(outstanding)
	);

	// receiver: one fresh ready decision per cycle
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// hang detector: any accepted item on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// One item on the input channel. Idle cycles are drawn before valid goes up;
	// once up, valid and payload hold until the handshake edge.
	task automatic put_item(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		char_byte  <= b;
		end_marker <= e;
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// end item: the byte lane carries junk that must be ignored
	task automatic put_end();
		put_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_item(s[i], 1'b0);
	endtask

	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		case ($urandom_range(3))
			0: c = 8'("0" + $urandom_range(9));
			1: c = 8'("a" + $urandom_range(25));
			2: c = 8'("A" + $urandom_range(25));
			default: c = ctt_pkg::CH_USCORE;
		endcase
		return c;
	endfunction

	// any byte that may sit inside a token body without ending it
	function automatic logic [7:0] rand_body_byte(input logic [7:0] avoid);
		logic [7:0] c;
		c = $urandom_range(1) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(8'h20, 8'h7E));
		if (c == ctt_pkg::CH_NL || c == avoid)
			c = "x";
		return c;
	endfunction

	task automatic put_blanks();
		repeat ($urandom_range(2)) begin
			case ($urandom_range(4))
				0: put_item(ctt_pkg::CH_SPACE, 1'b0);
				1: put_item(ctt_pkg::CH_TAB, 1'b0);
				2: put_item(ctt_pkg::CH_VT, 1'b0);
				3: put_item(ctt_pkg::CH_FF, 1'b0);
				default: put_item(ctt_pkg::CH_CR, 1'b0);
			endcase
		end
	endtask

	// identifiers, with keywords and near misses mixed in
	task automatic put_word();
		if ($urandom_range(2) == 0) begin
			case ($urandom_range(7))
				0: send_text("true");
				1: send_text("false");
				2: send_text("tru");
				3: send_text("fals");
				4: send_text("truex");
				5: send_text("false_");
				6: send_text("tRue");
				default: send_text("f9");
			endcase
		end else begin
			put_item($urandom_range(1) ? 8'("a" + $urandom_range(25)) : ctt_pkg::CH_USCORE,
				1'b0);
			repeat ($urandom_range(5))
				put_item(rand_word_char(), 1'b0);
		end
	endtask

	// quoted string; closed unless told otherwise
	task automatic put_string(input bit closed);
		logic [7:0] q;
		q = $urandom_range(1) ? ctt_pkg::CH_DQUOTE : ctt_pkg::CH_SQUOTE;
		put_item(q, 1'b0);
		repeat ($urandom_range(6))
			put_item(rand_body_byte(q), 1'b0);
		if (closed)
			put_item(q, 1'b0);
	endtask

	task automatic put_value();
		case ($urandom_range(5))
			0: repeat ($urandom_range(1, 5)) put_item(8'("0" + $urandom_range(9)), 1'b0);
			1, 2: put_string(1'b1);
			3: send_text("true");
			4: send_text("false");
			default: put_word();
		endcase
	endtask

	task automatic put_line();
		case ($urandom_range(9))
			0, 1: begin
				put_item(ctt_pkg::CH_OPEN, 1'b0);
				put_blanks();
				put_word();
				put_item(ctt_pkg::CH_CLOSE, 1'b0);
			end
			2, 3, 4, 5: begin
				put_word();
				put_blanks();
				put_item(ctt_pkg::CH_EQ, 1'b0);
				put_blanks();
				put_value();
			end
			6: begin
				put_item(ctt_pkg::CH_HASH, 1'b0);
				repeat ($urandom_range(6))
					put_item(rand_body_byte(ctt_pkg::CH_NUL), 1'b0);
			end
			7: put_blanks();
			8: begin
				// raw noise, newlines and high bytes included
				repeat ($urandom_range(1, 6))
					put_item(8'($urandom_range(1, 255)), 1'b0);
			end
			default: put_string(1'b0);
		endcase
		put_blanks();
		if ($urandom_range(7) == 0) begin
			put_item(ctt_pkg::CH_HASH, 1'b0);
			send_text(" note");
		end
		put_item(ctt_pkg::CH_NL, 1'b0);
	endtask

	// one whole text: a few lines, then one of several ways to finish it
	task automatic put_text();
		int n;
		repeat ($urandom_range(1, 5))
			put_line();
		case ($urandom_range(9))
			6: begin
				// zero byte; what follows is dropped until the end item
				put_item(ctt_pkg::CH_NUL, 1'b0);
				n = $urandom_range(3);
				repeat (n)
					put_item(8'($urandom_range(255)), 1'b0);
				items_sent -= n;
				put_end();
			end
			7: begin
				// end item lands inside an open token
				case ($urandom_range(2))
					0: put_string(1'b0);
					1: put_item(8'("0" + $urandom_range(9)), 1'b0);
					default: put_word();
				endcase
				put_end();
			end
			8: begin
				put_word();
				put_item(ctt_pkg::CH_NUL, 1'b0);
				put_end();
			end
			9: begin
				put_end();
				put_end();
			end
			default: put_end();
		endcase
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 37;
		recv_idle_pct <= 88;

		// directed: every token kind but STRING, a string broken by a newline, a comment,
		// both keywords, vertical tab, high byte, string cut by a zero byte,
		// a byte after the zero byte, end item after end and end on a fresh text
		send_text("[k]=9'a\n#\n");
		send_text("true false");
		put_item(ctt_pkg::CH_VT, 1'b0);
		put_item(8'h80, 1'b0);
		put_item(ctt_pkg::CH_DQUOTE, 1'b0);
		put_item(ctt_pkg::CH_NUL, 1'b0);
		put_item("b", 1'b0);
		put_end();
		put_end();

		// random texts in three pressure phases
		items_sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct <= 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct <= 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			while (items_sent < (phase + 1) * RANDOM_ITEMS / 3)
				put_text();
		end

		in_valid <= 1'b0;
		// let the checker take in the last accepted item
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
